>>> sv/rcmag_pkg.sv
package rcmag_pkg;

    localparam int TILE_SIZE   = 32;
    localparam int HALF_TILE   = TILE_SIZE / 2;
    localparam int MAX_REGIONS = 200;
    localparam int MAX_TILES   = 64;

    localparam int DIM_W   = 13;
    localparam int SCALE_W = 5;
    localparam int TILES_W = 7;
    localparam int BOX_W   = 12;
    localparam int ADDR_W  = 27;
    localparam int SLOT_W  = 8;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 6;
    localparam int TL_W    = 16;
    localparam int CX_W    = 17;
    localparam int MUL_W   = 13;
    localparam int MW_W    = 12;
    localparam int TY_W    = 11;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_X      = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE_Y      = 3'd3;
    localparam logic [IDX_W-1:0] REG_MOSAIC_COLS  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MOSAIC_ROWS  = 3'd5;

    localparam logic [1:0] KIND_TOP_LEFT = 2'd0;
    localparam logic [1:0] KIND_LUMA     = 2'd1;
    localparam logic [1:0] KIND_CHROMA   = 2'd2;
    localparam logic [1:0] KIND_CLEAR    = 2'd3;

    localparam logic ACTION_FRAME  = 1'b0;
    localparam logic ACTION_REGION = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [TILES_W-1:0] mosaic_cols;
        logic [TILES_W-1:0] mosaic_rows;
    } cfg_t;

    typedef struct packed {
        logic             action;
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_right;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_bottom;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [LEN_W-1:0]  copy_len;
        logic [TL_W-1:0]   top_left_x;
        logic [TL_W-1:0]   top_left_y;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [MUL_W-1:0]  a;
        logic [MUL_W-1:0]  b;
        logic [ADDR_W-1:0] c;
    } mac_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CX,
        ST_CY,
        ST_CLAMP,
        ST_TL,
        ST_LSRC,
        ST_WH,
        ST_CSRC,
        ST_MWMH,
        ST_CDST,
        ST_LDST,
        ST_ROW_L,
        ST_ROW_C
    } state_t;

endpackage

>>> sv/roi_crop_mosaic_address_gen_core.sv
// Plans the copying of square crops from an NV12 frame into the tiles of a mosaic.
// Input items arrive on the s_ channel: s_tuser selects frame start (0) or region (1),
// and s_tdata carries the blob box. Result items leave on the m_ channel with the
// command kind in m_tuser and m_tlast set on the final item caused by one input.
// Frame geometry, scale and mosaic size are written on the cfg_ channel while idle; the
// user must keep to this, as the block itself does not enforce it. A frame start keeps
// the block busy until its clear command goes to the output register. A region yields a
// top-left record after the states CX, CY and CLAMP; then, if its window is not empty and
// the mosaic has room, the setup states LSRC, WH, CSRC, MWMH, CDST and LDST follow, and
// a luma row copy for each window row and a chroma row copy for each even frame row.
// All multiplications except those by the tile size go through one shared multiply-add
// unit; row copies leave through the single output register as the receiver takes them.
// A region beyond the two-hundredth in a frame is taken and yields nothing.
// The next input item is taken only when the previous one has been fully planned.
// When the receiver stalls, the output register holds its item and planning halts at
// the next item to emit. Reset restores the default configuration and clears the slot
// position; no clearing pass is needed.
module roi_crop_mosaic_address_gen_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,  // box_left, box_right, box_top, box_bottom
    input  logic         s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,  // slot, src_addr, dst_addr, copy_len, top_left_x,
                                   // top_left_y, zero padding
    output logic [1:0]   m_tuser,  // kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    rcmag_pkg::cfg_t     cfg_reg;
    rcmag_pkg::item_t    in_item;
    rcmag_pkg::result_t  emit_data;
    rcmag_pkg::result_t  out_data_reg;
    rcmag_pkg::mac_req_t mac_req;
    logic [rcmag_pkg::ADDR_W-1:0] mac_res;
    logic emit_valid, emit_ready, out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd3840;
            cfg_reg.image_height <= 13'd2160;
            cfg_reg.scale_x      <= 5'd8;
            cfg_reg.scale_y      <= 5'd8;
            cfg_reg.mosaic_cols  <= 7'd20;
            cfg_reg.mosaic_rows  <= 7'd20;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcmag_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                rcmag_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                rcmag_pkg::REG_SCALE_X:      cfg_reg.scale_x      <= cfg_data[4:0];
                rcmag_pkg::REG_SCALE_Y:      cfg_reg.scale_y      <= cfg_data[4:0];
                rcmag_pkg::REG_MOSAIC_COLS:  cfg_reg.mosaic_cols  <= cfg_data[6:0];
                rcmag_pkg::REG_MOSAIC_ROWS:  cfg_reg.mosaic_rows  <= cfg_data[6:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_item.action     = s_tuser;
    assign in_item.box_left   = s_tdata[11:0];
    assign in_item.box_right  = s_tdata[23:12];
    assign in_item.box_top    = s_tdata[35:24];
    assign in_item.box_bottom = s_tdata[47:36];

    rcmag_mac u_mac (
        .req (mac_req),
        .res (mac_res)
    );

    rcmag_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .emit_valid (emit_valid),
        .emit_data  (emit_data),
        .emit_ready (emit_ready),
        .mac_req    (mac_req),
        .mac_res    (mac_res)
    );

    assign emit_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_ready)
            out_valid_reg <= emit_valid;
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
            out_data_reg <= emit_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.kind;
    assign m_tlast  = out_data_reg.last;
    assign m_tdata  = {4'd0, out_data_reg.top_left_y, out_data_reg.top_left_x,
                       out_data_reg.copy_len, out_data_reg.dst_addr,
                       out_data_reg.src_addr, out_data_reg.slot};

`ifndef SYNTH
    // A frame start always keeps the block busy while its clear command is planned.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == rcmag_pkg::ACTION_FRAME) |=> !s_tready)
        else $error("frame start item did not make the block busy");

    // A clear command is always the only and final item of its frame start.
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rcmag_pkg::KIND_CLEAR) |-> m_tlast)
        else $error("clear command without last");

    // Row copies move between one and a full tile of bytes.
    a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == rcmag_pkg::KIND_LUMA) || (m_tuser == rcmag_pkg::KIND_CHROMA))
        |-> (m_tdata[67:62] != 6'd0) && (m_tdata[67:62] <= 6'(rcmag_pkg::TILE_SIZE)))
        else $error("row copy length out of range");
`endif

endmodule

>>> sv/rcmag_mac.sv
module rcmag_mac (
    input  rcmag_pkg::mac_req_t              req,
    output logic [rcmag_pkg::ADDR_W-1:0]     res
);

    logic [2*rcmag_pkg::MUL_W-1:0] prod;

    assign prod = req.a * req.b;
    assign res  = rcmag_pkg::ADDR_W'(prod) + req.c;

endmodule

>>> sv/rcmag_ctrl.sv
module rcmag_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rcmag_pkg::cfg_t                   cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rcmag_pkg::item_t                  in_item,
    output logic                              emit_valid,
    output rcmag_pkg::result_t                emit_data,
    input  logic                              emit_ready,
    output rcmag_pkg::mac_req_t               mac_req,
    input  logic [rcmag_pkg::ADDR_W-1:0]      mac_res
);

    rcmag_pkg::state_t state_reg, state_next;

    logic [rcmag_pkg::SLOT_W-1:0] slot_count_reg;
    logic [rcmag_pkg::POS_W-1:0]  slot_col_reg;
    logic [rcmag_pkg::POS_W-1:0]  slot_row_reg;

    logic [rcmag_pkg::BOX_W-1:0]  sx_reg, sy_reg;
    logic [rcmag_pkg::SLOT_W-1:0] cur_slot_reg;
    logic [rcmag_pkg::POS_W-1:0]  cur_col_reg, cur_row_reg;
    logic [rcmag_pkg::CX_W-1:0]   cx_reg, cy_reg;
    logic [rcmag_pkg::DIM_W-1:0]  x0_reg, y0_reg, y1_reg, h_reg;
    logic [rcmag_pkg::LEN_W-1:0]  len_reg;
    logic [rcmag_pkg::TL_W-1:0]   tlx_reg, tly_reg;
    logic                         active_reg;
    logic [rcmag_pkg::ADDR_W-1:0] lsrc_reg, csrc_reg, ldst_reg, cdst_reg, scratch_reg;

    logic [rcmag_pkg::TILES_W-1:0] cols_cl, rows_cl;
    logic [rcmag_pkg::MW_W-1:0]    mw, mh;
    logic [rcmag_pkg::TY_W-1:0]    tx, ty;
    logic                          in_fire, emit_fire, last_row, room;
    logic [rcmag_pkg::BOX_W:0]     sum_x, sum_y;
    logic [rcmag_pkg::DIM_W-1:0]   y0_half_up;
    logic [rcmag_pkg::TILES_W-1:0] col_inc;

    logic [rcmag_pkg::CX_W-1:0] x0_c, y0_c;
    logic [rcmag_pkg::CX_W:0]   x1_raw, y1_raw, x1_c, y1_c;
    logic                       nx, ny;

    always_comb
    begin
        if (cfg.mosaic_cols == '0)
            cols_cl = rcmag_pkg::TILES_W'(1);
        else if (cfg.mosaic_cols > rcmag_pkg::TILES_W'(rcmag_pkg::MAX_TILES))
            cols_cl = rcmag_pkg::TILES_W'(rcmag_pkg::MAX_TILES);
        else
            cols_cl = cfg.mosaic_cols;
        if (cfg.mosaic_rows == '0)
            rows_cl = rcmag_pkg::TILES_W'(1);
        else if (cfg.mosaic_rows > rcmag_pkg::TILES_W'(rcmag_pkg::MAX_TILES))
            rows_cl = rcmag_pkg::TILES_W'(rcmag_pkg::MAX_TILES);
        else
            rows_cl = cfg.mosaic_rows;
    end

    assign mw = rcmag_pkg::MW_W'(cols_cl * rcmag_pkg::TILE_SIZE);
    assign mh = rcmag_pkg::MW_W'(rows_cl * rcmag_pkg::TILE_SIZE);
    assign tx = rcmag_pkg::TY_W'(cur_col_reg * rcmag_pkg::TILE_SIZE);
    assign ty = rcmag_pkg::TY_W'(cur_row_reg * rcmag_pkg::TILE_SIZE);

    assign in_fire   = in_valid && in_ready;
    assign emit_fire = emit_valid && emit_ready;
    assign last_row  = ({1'b0, h_reg} + 1'b1) == {1'b0, y1_reg};
    assign room      = {19'd0, cur_slot_reg} < mac_res;
    assign sum_x     = {1'b0, in_item.box_left} + {1'b0, in_item.box_right};
    assign sum_y     = {1'b0, in_item.box_top} + {1'b0, in_item.box_bottom};
    assign y0_half_up = {1'b0, y0_reg[rcmag_pkg::DIM_W-1:1]} + {12'd0, y0_reg[0]};
    assign col_inc   = {1'b0, slot_col_reg} + 1'b1;

    always_comb
    begin
        x0_c   = (cx_reg >= rcmag_pkg::CX_W'(rcmag_pkg::HALF_TILE))
                 ? cx_reg - rcmag_pkg::CX_W'(rcmag_pkg::HALF_TILE) : '0;
        y0_c   = (cy_reg >= rcmag_pkg::CX_W'(rcmag_pkg::HALF_TILE))
                 ? cy_reg - rcmag_pkg::CX_W'(rcmag_pkg::HALF_TILE) : '0;
        x1_raw = {1'b0, cx_reg} + (rcmag_pkg::CX_W+1)'(rcmag_pkg::HALF_TILE);
        y1_raw = {1'b0, cy_reg} + (rcmag_pkg::CX_W+1)'(rcmag_pkg::HALF_TILE);
        x1_c   = (x1_raw > {5'd0, cfg.image_width}) ? {5'd0, cfg.image_width} : x1_raw;
        y1_c   = (y1_raw > {5'd0, cfg.image_height}) ? {5'd0, cfg.image_height} : y1_raw;
        nx     = x1_c > {1'b0, x0_c};
        ny     = y1_c > {1'b0, y0_c};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcmag_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_item.action == rcmag_pkg::ACTION_FRAME)
                        state_next = rcmag_pkg::ST_CLEAR;
                    else if (slot_count_reg < rcmag_pkg::SLOT_W'(rcmag_pkg::MAX_REGIONS))
                        state_next = rcmag_pkg::ST_CX;
                end
            end
            rcmag_pkg::ST_CLEAR: if (emit_fire) state_next = rcmag_pkg::ST_IDLE;
            rcmag_pkg::ST_CX:    state_next = rcmag_pkg::ST_CY;
            rcmag_pkg::ST_CY:    state_next = rcmag_pkg::ST_CLAMP;
            rcmag_pkg::ST_CLAMP: state_next = rcmag_pkg::ST_TL;
            rcmag_pkg::ST_TL:
            begin
                if (emit_fire)
                    state_next = active_reg ? rcmag_pkg::ST_LSRC : rcmag_pkg::ST_IDLE;
            end
            rcmag_pkg::ST_LSRC:  state_next = rcmag_pkg::ST_WH;
            rcmag_pkg::ST_WH:    state_next = rcmag_pkg::ST_CSRC;
            rcmag_pkg::ST_CSRC:  state_next = rcmag_pkg::ST_MWMH;
            rcmag_pkg::ST_MWMH:  state_next = rcmag_pkg::ST_CDST;
            rcmag_pkg::ST_CDST:  state_next = rcmag_pkg::ST_LDST;
            rcmag_pkg::ST_LDST:  state_next = rcmag_pkg::ST_ROW_L;
            rcmag_pkg::ST_ROW_L:
            begin
                if (emit_fire)
                begin
                    if (!h_reg[0])
                        state_next = rcmag_pkg::ST_ROW_C;
                    else if (last_row)
                        state_next = rcmag_pkg::ST_IDLE;
                end
            end
            rcmag_pkg::ST_ROW_C:
            begin
                if (emit_fire)
                    state_next = last_row ? rcmag_pkg::ST_IDLE : rcmag_pkg::ST_ROW_L;
            end
            default: state_next = rcmag_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        emit_valid = 1'b0;
        emit_data  = '0;
        emit_data.slot = cur_slot_reg;
        mac_req    = '0;
        unique case (state_reg)
            rcmag_pkg::ST_IDLE: in_ready = 1'b1;
            rcmag_pkg::ST_CLEAR:
            begin
                mac_req.a          = {1'b0, mw};
                mac_req.b          = {1'b0, mh};
                emit_valid         = 1'b1;
                emit_data.kind     = rcmag_pkg::KIND_CLEAR;
                emit_data.slot     = '0;
                emit_data.dst_addr = mac_res;
                emit_data.last     = 1'b1;
            end
            rcmag_pkg::ST_CX:
            begin
                mac_req.a = {8'd0, cfg.scale_x};
                mac_req.b = {1'b0, sx_reg};
            end
            rcmag_pkg::ST_CY:
            begin
                mac_req.a = {8'd0, cfg.scale_y};
                mac_req.b = {1'b0, sy_reg};
            end
            rcmag_pkg::ST_CLAMP:
            begin
                mac_req.a = {6'd0, cols_cl};
                mac_req.b = {6'd0, rows_cl};
            end
            rcmag_pkg::ST_TL:
            begin
                emit_valid           = 1'b1;
                emit_data.kind       = rcmag_pkg::KIND_TOP_LEFT;
                emit_data.top_left_x = tlx_reg;
                emit_data.top_left_y = tly_reg;
                emit_data.last       = !active_reg;
            end
            rcmag_pkg::ST_LSRC:
            begin
                mac_req.a = y0_reg;
                mac_req.b = cfg.image_width;
                mac_req.c = {14'd0, x0_reg};
            end
            rcmag_pkg::ST_WH:
            begin
                mac_req.a = cfg.image_width;
                mac_req.b = cfg.image_height;
            end
            rcmag_pkg::ST_CSRC:
            begin
                mac_req.a = y0_half_up;
                mac_req.b = cfg.image_width;
                mac_req.c = scratch_reg + {14'd0, x0_reg};
            end
            rcmag_pkg::ST_MWMH:
            begin
                mac_req.a = {1'b0, mw};
                mac_req.b = {1'b0, mh};
            end
            rcmag_pkg::ST_CDST:
            begin
                mac_req.a = {3'd0, ty[rcmag_pkg::TY_W-1:1]};
                mac_req.b = {1'b0, mw};
                mac_req.c = scratch_reg + {16'd0, tx};
            end
            rcmag_pkg::ST_LDST:
            begin
                mac_req.a = {2'd0, ty};
                mac_req.b = {1'b0, mw};
                mac_req.c = {16'd0, tx};
            end
            rcmag_pkg::ST_ROW_L:
            begin
                emit_valid         = 1'b1;
                emit_data.kind     = rcmag_pkg::KIND_LUMA;
                emit_data.src_addr = lsrc_reg;
                emit_data.dst_addr = ldst_reg;
                emit_data.copy_len = len_reg;
                emit_data.last     = last_row && h_reg[0];
            end
            rcmag_pkg::ST_ROW_C:
            begin
                emit_valid         = 1'b1;
                emit_data.kind     = rcmag_pkg::KIND_CHROMA;
                emit_data.src_addr = csrc_reg;
                emit_data.dst_addr = cdst_reg;
                emit_data.copy_len = len_reg;
                emit_data.last     = last_row;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rcmag_pkg::ST_IDLE;
            slot_count_reg <= '0;
            slot_col_reg   <= '0;
            slot_row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (in_item.action == rcmag_pkg::ACTION_FRAME)
                begin
                    slot_count_reg <= '0;
                    slot_col_reg   <= '0;
                    slot_row_reg   <= '0;
                end
                else if (slot_count_reg < rcmag_pkg::SLOT_W'(rcmag_pkg::MAX_REGIONS))
                begin
                    slot_count_reg <= slot_count_reg + 1'b1;
                    if (col_inc >= cols_cl)
                    begin
                        slot_col_reg <= '0;
                        if (slot_row_reg != '1)
                            slot_row_reg <= slot_row_reg + 1'b1;
                    end
                    else
                        slot_col_reg <= col_inc[rcmag_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rcmag_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    sx_reg       <= sum_x[rcmag_pkg::BOX_W:1];
                    sy_reg       <= sum_y[rcmag_pkg::BOX_W:1];
                    cur_slot_reg <= slot_count_reg;
                    cur_col_reg  <= slot_col_reg;
                    cur_row_reg  <= slot_row_reg;
                end
            end
            rcmag_pkg::ST_CX: cx_reg <= mac_res[rcmag_pkg::CX_W-1:0];
            rcmag_pkg::ST_CY: cy_reg <= mac_res[rcmag_pkg::CX_W-1:0];
            rcmag_pkg::ST_CLAMP:
            begin
                x0_reg     <= x0_c[rcmag_pkg::DIM_W-1:0];
                y0_reg     <= y0_c[rcmag_pkg::DIM_W-1:0];
                y1_reg     <= y1_c[rcmag_pkg::DIM_W-1:0];
                len_reg    <= rcmag_pkg::LEN_W'(x1_c - {1'b0, x0_c});
                tlx_reg    <= (x0_c > rcmag_pkg::CX_W'(16'hFFFF)) ? '1 : x0_c[rcmag_pkg::TL_W-1:0];
                tly_reg    <= (y0_c > rcmag_pkg::CX_W'(16'hFFFF)) ? '1 : y0_c[rcmag_pkg::TL_W-1:0];
                active_reg <= room && nx && ny;
            end
            rcmag_pkg::ST_LSRC: lsrc_reg    <= mac_res;
            rcmag_pkg::ST_WH:   scratch_reg <= mac_res;
            rcmag_pkg::ST_CSRC: csrc_reg    <= mac_res;
            rcmag_pkg::ST_MWMH: scratch_reg <= mac_res;
            rcmag_pkg::ST_CDST: cdst_reg    <= mac_res;
            rcmag_pkg::ST_LDST:
            begin
                ldst_reg <= mac_res;
                h_reg    <= y0_reg;
            end
            rcmag_pkg::ST_ROW_L:
            begin
                if (emit_fire)
                begin
                    lsrc_reg <= lsrc_reg + {14'd0, cfg.image_width};
                    ldst_reg <= ldst_reg + {15'd0, mw};
                    if (h_reg[0])
                        h_reg <= h_reg + 1'b1;
                end
            end
            rcmag_pkg::ST_ROW_C:
            begin
                if (emit_fire)
                begin
                    csrc_reg <= csrc_reg + {14'd0, cfg.image_width};
                    cdst_reg <= cdst_reg + {15'd0, mw};
                    h_reg    <= h_reg + 1'b1;
                end
            end
            default: h_reg <= h_reg;
        endcase
    end

endmodule

>>> sim/roi_crop_mosaic_address_gen_core_tb.sv
module roi_crop_mosaic_address_gen_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 64;
    localparam int LONG_HOLD    = 400;
    localparam int N_DIRECTED   = 15;

    typedef struct packed {
        logic                         act;
        logic [rcmag_pkg::BOX_W-1:0]  bl;
        logic [rcmag_pkg::BOX_W-1:0]  br;
        logic [rcmag_pkg::BOX_W-1:0]  bt;
        logic [rcmag_pkg::BOX_W-1:0]  bb;
        logic                         typed;
        logic [1:0]                   kind;
        logic [rcmag_pkg::ADDR_W-1:0] dst;
        logic [rcmag_pkg::TL_W-1:0]   tlx;
        logic [rcmag_pkg::TL_W-1:0]   tly;
    } vector_t;

    // Rows with typed set carry their single result; the rest go through the planner.
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{rcmag_pkg::ACTION_FRAME,  12'd0,    12'd0,    12'd0,    12'd0,
          1'b1, rcmag_pkg::KIND_CLEAR,    27'd409600, 16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
          1'b1, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd32744, 16'd32744},
        '{rcmag_pkg::ACTION_REGION, 12'd0,    12'd0,    12'd0,    12'd0,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd1,    12'd2,    12'd3,    12'd4,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd479,  12'd479,  12'd269,  12'd269,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd0,    12'd4095, 12'd0,    12'd4095,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd200,  12'd240,  12'd100,  12'd140,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd480,  12'd480,  12'd270,  12'd270,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd482,  12'd482,  12'd100,  12'd100,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd100,  12'd100,  12'd272,  12'd272,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_FRAME,  12'd4095, 12'd4095, 12'd4095, 12'd4095,
          1'b1, rcmag_pkg::KIND_CLEAR,    27'd409600, 16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd2730, 12'd1365, 12'd1365, 12'd2730,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd3,    12'd4,    12'd2,    12'd3,
          1'b0, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd0},
        '{rcmag_pkg::ACTION_FRAME,  12'd2730, 12'd1365, 12'd2730, 12'd1365,
          1'b1, rcmag_pkg::KIND_CLEAR,    27'd409600, 16'd0,     16'd0},
        '{rcmag_pkg::ACTION_REGION, 12'd0,    12'd0,    12'd4095, 12'd4095,
          1'b1, rcmag_pkg::KIND_TOP_LEFT, 27'd0,      16'd0,     16'd32744}
    };

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [12:0]  cfg_data;

    // Planner copy of the registers and of the slot position.
    logic [rcmag_pkg::DIM_W-1:0]   frame_w = 13'd3840;
    logic [rcmag_pkg::DIM_W-1:0]   frame_h = 13'd2160;
    logic [rcmag_pkg::SCALE_W-1:0] zoom_x = 5'd8;
    logic [rcmag_pkg::SCALE_W-1:0] zoom_y = 5'd8;
    logic [rcmag_pkg::TILES_W-1:0] tiles_across = 7'd20;
    logic [rcmag_pkg::TILES_W-1:0] tiles_down = 7'd20;
    logic [rcmag_pkg::SLOT_W-1:0]  regions_taken = '0;
    logic [rcmag_pkg::POS_W-1:0]   tile_col = '0;
    logic [rcmag_pkg::POS_W-1:0]   tile_row = '0;

    rcmag_pkg::result_t item_cmds [$];
    rcmag_pkg::result_t planned_cmds [$];
    rcmag_pkg::result_t seen_cmd;
    rcmag_pkg::result_t due_cmd;
    rcmag_pkg::result_t no_cmd = '0;

    bit                 offer_typed = 1'b0;
    rcmag_pkg::result_t offer_want = '0;
    bit                 long_hold_req = 1'b0;
    int                 burst_left = 0;

    int mismatches = 0;
    int items_taken = 0;
    int cmds_seen = 0;
    int clears_planned = 0;
    int regions_ignored = 0;
    int regions_full = 0;
    int windows_empty = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    roi_crop_mosaic_address_gen_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint tile_count(input logic [rcmag_pkg::TILES_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > rcmag_pkg::MAX_TILES)
            return rcmag_pkg::MAX_TILES;
        return longint'(v);
    endfunction

    function automatic rcmag_pkg::result_t make_cmd(input logic [1:0] kind,
                                                    input longint slot,
                                                    input longint src, input longint dst,
                                                    input longint len, input longint tlx,
                                                    input longint tly);
        rcmag_pkg::result_t cmd;
        cmd.kind       = kind;
        cmd.slot       = rcmag_pkg::SLOT_W'(slot);
        cmd.src_addr   = rcmag_pkg::ADDR_W'(src);
        cmd.dst_addr   = rcmag_pkg::ADDR_W'(dst);
        cmd.copy_len   = rcmag_pkg::LEN_W'(len);
        cmd.top_left_x = (tlx > 65535) ? '1 : rcmag_pkg::TL_W'(tlx);
        cmd.top_left_y = (tly > 65535) ? '1 : rcmag_pkg::TL_W'(tly);
        cmd.last       = 1'b0;
        return cmd;
    endfunction

    function automatic void plan_commands(input logic act,
                                          input logic [rcmag_pkg::BOX_W-1:0] bl,
                                          input logic [rcmag_pkg::BOX_W-1:0] br,
                                          input logic [rcmag_pkg::BOX_W-1:0] bt,
                                          input logic [rcmag_pkg::BOX_W-1:0] bb);
        longint  cols, rows, mw, mh, fw, fh, cx, cy, x0, x1, y0, y1;
        longint  slot, len, tx, ty, h, rr;
        rcmag_pkg::result_t cmd;
        item_cmds.delete();
        cols = tile_count(tiles_across);
        rows = tile_count(tiles_down);
        mw = cols * rcmag_pkg::TILE_SIZE;
        mh = rows * rcmag_pkg::TILE_SIZE;
        if (act == rcmag_pkg::ACTION_FRAME)
        begin
            regions_taken = '0;
            tile_col = '0;
            tile_row = '0;
            cmd = make_cmd(rcmag_pkg::KIND_CLEAR, 0, 0, mw * mh, 0, 0, 0);
            cmd.last = 1'b1;
            item_cmds = {item_cmds, cmd};
            clears_planned++;
            return;
        end
        if (regions_taken >= rcmag_pkg::MAX_REGIONS)
        begin
            regions_ignored++;
            return;
        end
        fw = longint'(frame_w);
        fh = longint'(frame_h);
        cx = longint'(zoom_x) * ((longint'(bl) + longint'(br)) >> 1);
        cy = longint'(zoom_y) * ((longint'(bt) + longint'(bb)) >> 1);
        x0 = (cx - rcmag_pkg::HALF_TILE < 0) ? 0 : cx - rcmag_pkg::HALF_TILE;
        x1 = (cx + rcmag_pkg::HALF_TILE > fw) ? fw : cx + rcmag_pkg::HALF_TILE;
        y0 = (cy - rcmag_pkg::HALF_TILE < 0) ? 0 : cy - rcmag_pkg::HALF_TILE;
        y1 = (cy + rcmag_pkg::HALF_TILE > fh) ? fh : cy + rcmag_pkg::HALF_TILE;
        slot = longint'(regions_taken);
        cmd = make_cmd(rcmag_pkg::KIND_TOP_LEFT, slot, 0, 0, 0, x0, y0);
        item_cmds = {item_cmds, cmd};
        if (slot >= cols * rows)
            regions_full++;
        else if (x1 <= x0 || y1 <= y0)
            windows_empty++;
        else
        begin
            len = x1 - x0;
            tx = longint'(tile_col) * rcmag_pkg::TILE_SIZE;
            ty = longint'(tile_row) * rcmag_pkg::TILE_SIZE;
            for (h = y0; h < y1; h++)
            begin
                rr = h - y0;
                cmd = make_cmd(rcmag_pkg::KIND_LUMA, slot, h * fw + x0,
                               (ty + rr) * mw + tx, len, 0, 0);
                item_cmds = {item_cmds, cmd};
                if ((h & 1) == 0)
                begin
                    cmd = make_cmd(rcmag_pkg::KIND_CHROMA, slot,
                                   fw * fh + (h >> 1) * fw + x0,
                                   mw * mh + ((ty >> 1) + (rr >> 1)) * mw + tx,
                                   len, 0, 0);
                    item_cmds = {item_cmds, cmd};
                end
            end
        end
        item_cmds[item_cmds.size() - 1].last = 1'b1;
        regions_taken = regions_taken + 1'b1;
        if (longint'(tile_col) + 1 >= cols)
        begin
            tile_col = '0;
            if (tile_row < 63)
                tile_row = tile_row + 1'b1;
        end
        else
            tile_col = tile_col + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint unsigned seen,
                               input longint unsigned due);
        if (seen != due)
            report_mismatch($sformatf("command %0d %s is 0x%0h, planned 0x%0h",
                                      cmds_seen, name, seen, due));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            plan_commands(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[35:24],
                          s_tdata[47:36]);
            if (offer_typed)
                planned_cmds = {planned_cmds, offer_want};
            else
                planned_cmds = {planned_cmds, item_cmds};
            items_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_cmd.kind       = m_tuser;
            seen_cmd.slot       = m_tdata[7:0];
            seen_cmd.src_addr   = m_tdata[34:8];
            seen_cmd.dst_addr   = m_tdata[61:35];
            seen_cmd.copy_len   = m_tdata[67:62];
            seen_cmd.top_left_x = m_tdata[83:68];
            seen_cmd.top_left_y = m_tdata[99:84];
            seen_cmd.last       = m_tlast;
            if (planned_cmds.size() == 0)
                report_mismatch($sformatf("command %0d arrived with nothing planned (kind %0d)",
                                          cmds_seen, seen_cmd.kind));
            else
            begin
                due_cmd = planned_cmds.pop_front();
                check_field("kind", seen_cmd.kind, due_cmd.kind);
                check_field("slot", seen_cmd.slot, due_cmd.slot);
                check_field("src_addr", seen_cmd.src_addr, due_cmd.src_addr);
                check_field("dst_addr", seen_cmd.dst_addr, due_cmd.dst_addr);
                check_field("copy_len", seen_cmd.copy_len, due_cmd.copy_len);
                check_field("top_left_x", seen_cmd.top_left_x, due_cmd.top_left_x);
                check_field("top_left_y", seen_cmd.top_left_y, due_cmd.top_left_y);
                check_field("last", seen_cmd.last, due_cmd.last);
            end
            cmds_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: %0d cycles without a handshake, %0d commands outstanding",
                         quiet_cycles, planned_cmds.size());
                $display("** roi_crop_mosaic_address_gen_core: FAILED **");
                $finish;
            end
        end
    end

    // The receiver switches between stall patterns and honors one long hold-off on request.
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 99) < 70);
                    2: m_tready <= ((tick % 5) != 0);
                    default: m_tready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    task automatic send_item(input logic act, input logic [47:0] data, input bit typed,
                             input rcmag_pkg::result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 4);
                2: gap = $urandom_range(5, 20);
                default: gap = $urandom_range(20, 70);
            endcase
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= data;
        offer_typed = typed;
        offer_want = want;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain(input bit settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (planned_cmds.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_TICKS) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [rcmag_pkg::IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[12:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rcmag_pkg::REG_IMAGE_WIDTH:  frame_w = value[rcmag_pkg::DIM_W-1:0];
            rcmag_pkg::REG_IMAGE_HEIGHT: frame_h = value[rcmag_pkg::DIM_W-1:0];
            rcmag_pkg::REG_SCALE_X:      zoom_x = value[rcmag_pkg::SCALE_W-1:0];
            rcmag_pkg::REG_SCALE_Y:      zoom_y = value[rcmag_pkg::SCALE_W-1:0];
            rcmag_pkg::REG_MOSAIC_COLS:  tiles_across = value[rcmag_pkg::TILES_W-1:0];
            rcmag_pkg::REG_MOSAIC_ROWS:  tiles_down = value[rcmag_pkg::TILES_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned sx,
                             input int unsigned sy, input int unsigned cols,
                             input int unsigned rows);
        write_reg(rcmag_pkg::REG_IMAGE_WIDTH, w);
        write_reg(rcmag_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(rcmag_pkg::REG_SCALE_X, sx);
        write_reg(rcmag_pkg::REG_SCALE_Y, sy);
        write_reg(rcmag_pkg::REG_MOSAIC_COLS, cols);
        write_reg(rcmag_pkg::REG_MOSAIC_ROWS, rows);
        settings_used++;
    endtask

    // Most boxes are centered so that the window lands in or near the frame.
    function automatic logic [47:0] region_box();
        logic [rcmag_pkg::BOX_W-1:0] l, r, t, b;
        int unsigned reach_x, reach_y, cxb, cyb, dx, dy;
        case ($urandom_range(0, 9))
            0:
            begin
                l = rcmag_pkg::BOX_W'($urandom_range(0, 4095));
                r = rcmag_pkg::BOX_W'($urandom_range(0, 4095));
                t = rcmag_pkg::BOX_W'($urandom_range(0, 4095));
                b = rcmag_pkg::BOX_W'($urandom_range(0, 4095));
            end
            1:
            begin
                l = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                r = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                t = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                b = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end
            default:
            begin
                reach_x = (frame_w + rcmag_pkg::HALF_TILE) / zoom_x;
                reach_y = (frame_h + rcmag_pkg::HALF_TILE) / zoom_y;
                if (reach_x > 4095)
                    reach_x = 4095;
                if (reach_y > 4095)
                    reach_y = 4095;
                cxb = $urandom_range(0, reach_x);
                cyb = $urandom_range(0, reach_y);
                dx = $urandom_range(0, 40);
                dy = $urandom_range(0, 40);
                l = rcmag_pkg::BOX_W'((cxb >= dx) ? cxb - dx : 0);
                t = rcmag_pkg::BOX_W'((cyb >= dy) ? cyb - dy : 0);
                r = rcmag_pkg::BOX_W'((cxb + dx + 1 > 4095) ? 4095
                                      : cxb + dx + $urandom_range(0, 1));
                b = rcmag_pkg::BOX_W'((cyb + dy + 1 > 4095) ? 4095
                                      : cyb + dy + $urandom_range(0, 1));
            end
        endcase
        return {b, t, r, l};
    endfunction

    task automatic run_phase(input int count, input bit single_frame, input int hold_at,
                             input int pause_at);
        int   k;
        logic act;
        send_item(rcmag_pkg::ACTION_FRAME, region_box(), 1'b0, no_cmd);
        for (k = 0; k < count; k++)
        begin
            if (k == hold_at)
                long_hold_req = 1'b1;
            if (k == pause_at)
                drain(1'b0);
            act = (!single_frame && $urandom_range(0, 19) == 0) ? rcmag_pkg::ACTION_FRAME
                                                                 : rcmag_pkg::ACTION_REGION;
            send_item(act, region_box(), 1'b0, no_cmd);
        end
        drain(1'b1);
    endtask

    initial
    begin
        int                 i;
        int                 p;
        rcmag_pkg::result_t want;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
        begin
            want = make_cmd(DIRECTED[i].kind, 0, 0, DIRECTED[i].dst, 0,
                            DIRECTED[i].tlx, DIRECTED[i].tly);
            want.last = 1'b1;
            send_item(DIRECTED[i].act,
                      {DIRECTED[i].bb, DIRECTED[i].bt, DIRECTED[i].br, DIRECTED[i].bl},
                      DIRECTED[i].typed, want);
        end
        drain(1'b1);

        configure(8191, 8191, 16, 16, 64, 64);
        run_phase(56, 1'b0, 20, -1);
        // One long frame on a two-tile mosaic runs past the region limit.
        configure(64, 48, 1, 3, 1, 2);
        run_phase(212, 1'b1, -1, -1);
        configure(32, 32, 1, 1, 1, 1);
        run_phase(30, 1'b0, -1, -1);
        for (p = 0; p < 4; p++)
        begin
            configure($urandom_range(32, 8191), $urandom_range(32, 8191), $urandom_range(1, 16),
                      $urandom_range(1, 16), $urandom_range(1, 64), $urandom_range(1, 64));
            run_phase(45, 1'b0, -1, (p == 0) ? 15 : -1);
        end

        $display("Run covered %0d input items and %0d commands over %0d register settings.",
                 items_taken, cmds_seen, settings_used);
        $display("It saw %0d clears, %0d regions past the limit, %0d on a full mosaic, %0d empty.",
                 clears_planned, regions_ignored, regions_full, windows_empty);
        if (mismatches == 0)
            $display("** roi_crop_mosaic_address_gen_core: PASSED **");
        else
            $display("** roi_crop_mosaic_address_gen_core: FAILED **");
        $finish;
    end

endmodule
